FILE: design/plgs_pkg.sv
// ----------------------------------------------------------------------------
// plgs_pkg - shared types and constants of the parabolic/golden line search
// Field widths, fixed-point formats, reset values and the result word layout.
// ----------------------------------------------------------------------------
package plgs_pkg;

  localparam int unsigned STEP_FRAC_BITS   = 24;
  localparam int unsigned ENERGY_FRAC_BITS = 24;

  localparam int unsigned STEP_W   = 32;
  localparam int unsigned ENERGY_W = 48;
  localparam int unsigned TOL_W    = 25;
  localparam int unsigned PROBE_W  = 31;
  localparam int unsigned ITER_W   = 4;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Golden ratio 0.3819660 in Q0.30
  localparam logic [28:0] GOLD_Q30 = 29'd410132870;

  localparam logic [TOL_W-1:0] STEP_TOL_RST =
    TOL_W'(((64'd1 << STEP_FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam logic [TOL_W-1:0] ENERGY_TOL_RST =
    TOL_W'(((64'd1 << ENERGY_FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam logic [PROBE_W-1:0] FIRST_PROBE_RST  =
    PROBE_W'((64'd1 << STEP_FRAC_BITS) / 64'd100);
  localparam logic [PROBE_W-1:0] SECOND_PROBE_RST =
    PROBE_W'((64'd2 << STEP_FRAC_BITS) / 64'd100);
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 4'd11;

  // Register indexes (byte address 4*index)
  localparam logic [2:0] REG_STEP_TOL     = 3'd0;
  localparam logic [2:0] REG_ENERGY_TOL   = 3'd1;
  localparam logic [2:0] REG_FIRST_PROBE  = 3'd2;
  localparam logic [2:0] REG_SECOND_PROBE = 3'd3;
  localparam logic [2:0] REG_MAX_ITER     = 3'd4;

  // Request codes
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic signed [STEP_W-1:0]   trial_step;
    logic                       done_res;
    logic                       search_failed;
    logic signed [STEP_W-1:0]   best_step;
    logic signed [ENERGY_W-1:0] best_energy;
  } plgs_res_t;

endpackage

FILE: design/plgs_in_if.sv
// ----------------------------------------------------------------------------
// plgs_in_if - input word channel of the line search
// Valid/ready channel carrying a start or an energy report.
// ----------------------------------------------------------------------------
interface plgs_in_if import plgs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [ENERGY_W-1:0] energy;
  logic                       energy_ok;

  modport source (output valid, req_type, energy, energy_ok, input ready);
  modport sink   (input valid, req_type, energy, energy_ok, output ready);
endinterface

FILE: design/plgs_out_if.sv
// ----------------------------------------------------------------------------
// plgs_out_if - result word channel of the line search
// Valid/ready channel carrying the next trial step or the final best point.
// ----------------------------------------------------------------------------
interface plgs_out_if import plgs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [STEP_W-1:0]   trial_step;
  logic                       done_res;
  logic                       search_failed;
  logic signed [STEP_W-1:0]   best_step;
  logic signed [ENERGY_W-1:0] best_energy;

  modport source (output valid, trial_step, done_res, search_failed, best_step,
                  best_energy, input ready);
  modport sink   (input valid, trial_step, done_res, search_failed, best_step,
                  best_energy, output ready);
endinterface

FILE: design/parabolic_golden_line_search_unit.sv
// ----------------------------------------------------------------------------
// parabolic_golden_line_search_unit - line minimization controller
// Keeps a three-point step bracket and requests parabolic or golden points.
// ----------------------------------------------------------------------------
// Every accepted word yields one result word, except an energy report while no
// search is open, which is dropped. Starts and the first two probe reports are
// staged at once and move to the output register when it is free. The third
// probe report and any later report that leads to a parabolic point run six
// shift-add multiplications (a load, then shift-add steps) on one 128-bit
// accumulator to build the numerator and denominator, then a restoring divider
// yields one quotient bit a cycle. Golden points use one 33x29 multiplier. The
// input is not ready while a word is worked on; a finished result waits in the
// output register without blocking the input.
module parabolic_golden_line_search_unit import plgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  plgs_in_if.sink           req_i,
  plgs_out_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_WAIT, S_EMIT, S_TAIL, S_GOLD, S_GOLD2, S_MLOAD, S_MRUN, S_DCHK, S_DRUN, S_DFIN
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_E0, PH_E1, PH_E2, PH_PARA, PH_GOLD
  } phase_e;

  // Configuration registers
  logic [TOL_W-1:0]   step_tol_q, energy_tol_q;
  logic [PROBE_W-1:0] first_probe_q, second_probe_q;
  logic [ITER_W-1:0]  max_iter_q;

  // Search state
  state_e                     st_q;
  phase_e                     ph_q;
  logic signed [STEP_W-1:0]   s_q [3];
  logic signed [ENERGY_W-1:0] e_q [3];
  logic signed [STEP_W-1:0]   pend_q;
  logic [ITER_W-1:0]          iter_q;
  logic                       gside_q;
  plgs_res_t                  res_q, out_q;
  logic                       ov_q;

  // Shared multiply/divide datapath
  logic [2:0]   op_q;
  logic [5:0]   mcnt_q;
  logic [6:0]   dcnt_q;
  logic [127:0] acc_q, mcand_q, a_q, b_q, rem_q, quo_q;
  logic [48:0]  mplier_q;
  logic         sub_q, an_q, bn_q;
  logic [65:0]  sq10_q, sq12_q;
  logic [61:0]  gprod_q;
  logic         gneg_q;

  // APB port
  logic [2:0] ridx;
  logic       wr_en;
  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (ridx)
      REG_STEP_TOL:     prdata = DATA_W'(step_tol_q);
      REG_ENERGY_TOL:   prdata = DATA_W'(energy_tol_q);
      REG_FIRST_PROBE:  prdata = DATA_W'(first_probe_q);
      REG_SECOND_PROBE: prdata = DATA_W'(second_probe_q);
      REG_MAX_ITER:     prdata = DATA_W'(max_iter_q);
      default:          prdata = '0;
    endcase
  end

  // Bracket differences
  logic signed [32:0] b10, b12, d02;
  logic signed [48:0] d12, d10;
  logic [32:0]        m10, m12, md02;
  logic [48:0]        md12, md10;
  assign b10  = {s_q[1][31], s_q[1]} - {s_q[0][31], s_q[0]};
  assign b12  = {s_q[1][31], s_q[1]} - {s_q[2][31], s_q[2]};
  assign d02  = {s_q[0][31], s_q[0]} - {s_q[2][31], s_q[2]};
  assign d12  = {e_q[1][47], e_q[1]} - {e_q[2][47], e_q[2]};
  assign d10  = {e_q[1][47], e_q[1]} - {e_q[0][47], e_q[0]};
  assign m10  = b10[32] ? 33'(-b10) : 33'(b10);
  assign m12  = b12[32] ? 33'(-b12) : 33'(b12);
  assign md02 = d02[32] ? 33'(-d02) : 33'(d02);
  assign md12 = d12[48] ? 49'(-d12) : 49'(d12);
  assign md10 = d10[48] ? 49'(-d10) : 49'(d10);

  // Multiply step: add or subtract the shifted multiplicand
  logic [127:0] acc_d;
  assign acc_d = acc_q + (mplier_q[0] ? (sub_q ? -mcand_q : mcand_q) : 128'd0);

  // Divide step: shift in a numerator bit and try a subtract
  logic [127:0] rem_sh, rem_sub;
  logic         rem_ge;
  assign rem_sh  = {rem_q[126:0], a_q[127]};
  assign rem_ge  = rem_sh >= b_q;
  assign rem_sub = rem_sh - b_q;

  // Final parabolic point: clamp quotient, apply sign, saturate
  logic [34:0]        qc;
  logic signed [36:0] pv;
  logic signed [31:0] ppt;
  assign qc  = ((|quo_q[127:35]) || (quo_q[34] && (|quo_q[33:0]))) ? 35'h400000000
                                                                    : quo_q[34:0];
  assign pv  = (an_q != bn_q) ? ({{5{s_q[1][31]}}, s_q[1]} + {2'b00, qc})
                              : ({{5{s_q[1][31]}}, s_q[1]} - {2'b00, qc});
  assign ppt = (pv > 37'sd2147483647)  ? 32'sh7fffffff :
               (pv < -37'sd2147483648) ? 32'sh80000000 : pv[31:0];

  // Golden point pieces; the scaled side is the upper one, s2 unless s0 > s2
  logic               gt2;
  logic signed [32:0] gdiff;
  logic [32:0]        gmag;
  logic [31:0]        gr;
  logic signed [33:0] gnp;
  assign gt2   = !(s_q[0] > s_q[2]);
  assign gdiff = gt2 ? ({s_q[2][31], s_q[2]} - {s_q[1][31], s_q[1]})
                     : ({s_q[0][31], s_q[0]} - {s_q[1][31], s_q[1]});
  assign gmag  = gdiff[32] ? 33'(-gdiff) : 33'(gdiff);
  assign gr    = 32'((gprod_q + 62'd536870912) >> 30);
  assign gnp   = gneg_q ? ({{2{s_q[1][31]}}, s_q[1]} - {2'b00, gr})
                        : ({{2{s_q[1][31]}}, s_q[1]} + {2'b00, gr});

  // Tail step pieces
  logic [ITER_W-1:0] iter_inc;
  assign iter_inc = iter_q + 1'b1;

  // Input word decode
  logic signed [ENERGY_W-1:0] ein;
  logic signed [48:0]         de2, de0;
  logic                       in_fire;
  assign ein     = req_i.energy;
  assign de2     = {e_q[2][47], e_q[2]} - {ein[47], ein};
  assign de0     = {e_q[0][47], e_q[0]} - {ein[47], ein};
  assign in_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (st_q == S_WAIT);

  // Load the output register when a staged word may move in
  logic emit_go;
  assign emit_go = (st_q == S_EMIT) && (!ov_q || rsp_o.ready);

  // Ordering of the three probes
  logic signed [STEP_W-1:0]   o_s0, o_s1, o_s2, x_s1;
  logic signed [ENERGY_W-1:0] o_e0, o_e1, o_e2, x_e1;
  always_comb begin
    if (e_q[1] > e_q[0]) begin
      o_s0 = s_q[1]; o_e0 = e_q[1]; x_s1 = s_q[0]; x_e1 = e_q[0];
    end else begin
      o_s0 = s_q[0]; o_e0 = e_q[0]; x_s1 = s_q[1]; x_e1 = e_q[1];
    end
    if (x_e1 > ein) begin
      o_s1 = pend_q; o_e1 = ein; o_s2 = x_s1; o_e2 = x_e1;
    end else begin
      o_s1 = x_s1; o_e1 = x_e1; o_s2 = pend_q; o_e2 = ein;
    end
  end

  // Output channel
  assign rsp_o.valid         = ov_q;
  assign rsp_o.trial_step    = out_q.trial_step;
  assign rsp_o.done_res      = out_q.done_res;
  assign rsp_o.search_failed = out_q.search_failed;
  assign rsp_o.best_step     = out_q.best_step;
  assign rsp_o.best_energy   = out_q.best_energy;

  // Sequencer, bracket and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_tol_q     <= STEP_TOL_RST;
      energy_tol_q   <= ENERGY_TOL_RST;
      first_probe_q  <= FIRST_PROBE_RST;
      second_probe_q <= SECOND_PROBE_RST;
      max_iter_q     <= MAX_ITER_RST;
      st_q    <= S_WAIT;
      ph_q    <= PH_IDLE;
      for (int i = 0; i < 3; i++) begin
        s_q[i] <= '0;
        e_q[i] <= '0;
      end
      pend_q  <= '0;
      iter_q  <= '0;
      gside_q <= 1'b0;
      ov_q    <= 1'b0;
      op_q    <= '0;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      // Configuration writes
      if (wr_en) begin
        case (ridx)
          REG_STEP_TOL:     step_tol_q     <= pwdata[TOL_W-1:0];
          REG_ENERGY_TOL:   energy_tol_q   <= pwdata[TOL_W-1:0];
          REG_FIRST_PROBE:  first_probe_q  <= pwdata[PROBE_W-1:0];
          REG_SECOND_PROBE: second_probe_q <= pwdata[PROBE_W-1:0];
          REG_MAX_ITER:     max_iter_q     <= pwdata[ITER_W-1:0];
          default: ;
        endcase
      end

      // Load a staged word, or drop the result word once taken
      if (emit_go) ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;

      unique case (st_q)
        S_WAIT: begin
          if (in_fire) begin
            if (req_i.req_type == REQ_START) begin
              for (int i = 0; i < 3; i++) begin
                s_q[i] <= '0;
                e_q[i] <= '0;
              end
              iter_q  <= '0;
              gside_q <= 1'b0;
              pend_q  <= '0;
              ph_q    <= PH_E0;
              res_q   <= '{trial_step: '0, done_res: 1'b0, search_failed: 1'b0,
                           best_step: '0, best_energy: '0};
              st_q    <= S_EMIT;
            end else begin
              unique case (ph_q)
                PH_IDLE: ;
                PH_E0: begin
                  if (!req_i.energy_ok) begin
                    ph_q  <= PH_IDLE;
                    res_q <= '{trial_step: '0, done_res: 1'b1, search_failed: 1'b1,
                               best_step: '0, best_energy: '0};
                  end else begin
                    s_q[0] <= pend_q;
                    e_q[0] <= ein;
                    pend_q <= STEP_W'(first_probe_q);
                    ph_q   <= PH_E1;
                    res_q  <= '{trial_step: STEP_W'(first_probe_q), done_res: 1'b0,
                                search_failed: 1'b0, best_step: '0, best_energy: '0};
                  end
                  st_q <= S_EMIT;
                end
                PH_E1: begin
                  s_q[1] <= pend_q;
                  e_q[1] <= ein;
                  pend_q <= STEP_W'(second_probe_q);
                  ph_q   <= PH_E2;
                  res_q  <= '{trial_step: STEP_W'(second_probe_q), done_res: 1'b0,
                              search_failed: 1'b0, best_step: '0, best_energy: '0};
                  st_q   <= S_EMIT;
                end
                PH_E2: begin
                  s_q[0] <= o_s0; e_q[0] <= o_e0;
                  s_q[1] <= o_s1; e_q[1] <= o_e1;
                  s_q[2] <= o_s2; e_q[2] <= o_e2;
                  iter_q <= '0;
                  op_q   <= '0;
                  st_q   <= S_MLOAD;
                end
                PH_PARA: begin
                  if (ein < e_q[1]) begin
                    if (e_q[2] > e_q[0]) begin
                      s_q[2] <= s_q[1]; e_q[2] <= e_q[1];
                    end else begin
                      s_q[0] <= s_q[1]; e_q[0] <= e_q[1];
                    end
                    s_q[1] <= pend_q; e_q[1] <= ein;
                    st_q   <= S_TAIL;
                  end else if (de2 > $signed({24'd0, energy_tol_q})) begin
                    s_q[2] <= pend_q; e_q[2] <= ein;
                    st_q   <= S_TAIL;
                  end else if (de0 > $signed({24'd0, energy_tol_q})) begin
                    s_q[0] <= pend_q; e_q[0] <= ein;
                    st_q   <= S_TAIL;
                  end else begin
                    st_q <= S_GOLD;
                  end
                end
                PH_GOLD: begin
                  if (ein < e_q[1]) begin
                    if (gside_q) begin
                      s_q[2] <= s_q[1]; e_q[2] <= e_q[1];
                    end else begin
                      s_q[0] <= s_q[1]; e_q[0] <= e_q[1];
                    end
                    s_q[1] <= pend_q; e_q[1] <= ein;
                    st_q   <= S_GOLD;
                  end else if (ein < (gside_q ? e_q[2] : e_q[0])) begin
                    if (gside_q) begin
                      s_q[2] <= pend_q; e_q[2] <= ein;
                    end else begin
                      s_q[0] <= pend_q; e_q[0] <= ein;
                    end
                    st_q <= S_GOLD;
                  end else begin
                    st_q <= S_TAIL;
                  end
                end
                default: ;
              endcase
            end
          end
        end

        // Hand the staged word to the output register
        S_EMIT: begin
          if (emit_go) begin
            out_q <= res_q;
            st_q  <= S_WAIT;
          end
        end

        // Count the iteration, then stop or go for a parabolic point
        S_TAIL: begin
          iter_q <= iter_inc;
          if (iter_inc >= max_iter_q ||
              !(md02 > {7'd0, step_tol_q, 1'b0})) begin
            ph_q  <= PH_IDLE;
            res_q <= '{trial_step: '0, done_res: 1'b1, search_failed: 1'b0,
                       best_step: s_q[1], best_energy: e_q[1]};
            st_q  <= S_EMIT;
          end else begin
            op_q <= '0;
            st_q <= S_MLOAD;
          end
        end

        // Golden step: check width, then scale the upper side
        S_GOLD: begin
          if (md02 < {8'd0, step_tol_q}) begin
            st_q <= S_TAIL;
          end else begin
            gprod_q <= gmag * GOLD_Q30;
            gneg_q  <= gdiff[32];
            gside_q <= gt2;
            st_q    <= S_GOLD2;
          end
        end

        S_GOLD2: begin
          if (gr == '0) begin
            st_q <= S_TAIL;
          end else begin
            pend_q <= gnp[31:0];
            ph_q   <= PH_GOLD;
            res_q  <= '{trial_step: gnp[31:0], done_res: 1'b0, search_failed: 1'b0,
                        best_step: '0, best_energy: '0};
            st_q   <= S_EMIT;
          end
        end

        // Load one product term into the shared accumulator
        S_MLOAD: begin
          mcnt_q <= '0;
          case (op_q)
            3'd0: begin
              acc_q <= '0; mcand_q <= 128'(m10); mplier_q <= 49'(m10); sub_q <= 1'b0;
            end
            3'd1: begin
              acc_q <= '0; mcand_q <= 128'(m12); mplier_q <= 49'(m12); sub_q <= 1'b0;
            end
            3'd2: begin
              acc_q <= '0; mcand_q <= 128'(sq10_q); mplier_q <= md12; sub_q <= d12[48];
            end
            3'd3: begin
              mcand_q <= 128'(sq12_q); mplier_q <= md10; sub_q <= !d10[48];
            end
            3'd4: begin
              acc_q <= '0; mcand_q <= 128'(m10); mplier_q <= md12;
              sub_q <= b10[32] ^ d12[48];
            end
            default: begin
              mcand_q <= 128'(m12); mplier_q <= md10;
              sub_q <= !(b12[32] ^ d10[48]);
            end
          endcase
          st_q <= S_MRUN;
        end

        // Shift-add one multiplier bit a cycle
        S_MRUN: begin
          acc_q    <= acc_d;
          mcand_q  <= {mcand_q[126:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[48:1]};
          mcnt_q   <= mcnt_q + 1'b1;
          if (mcnt_q == 6'd48) begin
            case (op_q)
              3'd0: sq10_q <= acc_d[65:0];
              3'd1: sq12_q <= acc_d[65:0];
              3'd3: a_q    <= acc_d;
              3'd5: b_q    <= acc_d;
              default: ;
            endcase
            if (op_q == 3'd5) begin
              st_q <= S_DCHK;
            end else begin
              op_q <= op_q + 1'b1;
              st_q <= S_MLOAD;
            end
          end
        end

        // Zero denominator keeps the middle step, else set up the divider
        S_DCHK: begin
          if (b_q == '0) begin
            pend_q <= s_q[1];
            ph_q   <= PH_PARA;
            res_q  <= '{trial_step: s_q[1], done_res: 1'b0, search_failed: 1'b0,
                        best_step: '0, best_energy: '0};
            st_q   <= S_EMIT;
          end else begin
            an_q   <= a_q[127];
            bn_q   <= b_q[127];
            a_q    <= a_q[127] ? -a_q : a_q;
            b_q    <= (b_q[127] ? -b_q : b_q) << 1;
            rem_q  <= '0;
            quo_q  <= '0;
            dcnt_q <= '0;
            st_q   <= S_DRUN;
          end
        end

        // Restoring divide, one quotient bit a cycle
        S_DRUN: begin
          a_q    <= {a_q[126:0], 1'b0};
          rem_q  <= rem_ge ? rem_sub : rem_sh;
          quo_q  <= {quo_q[126:0], rem_ge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 7'd127) st_q <= S_DFIN;
        end

        S_DFIN: begin
          pend_q <= ppt;
          ph_q   <= PH_PARA;
          res_q  <= '{trial_step: ppt, done_res: 1'b0, search_failed: 1'b0,
                      best_step: '0, best_energy: '0};
          st_q   <= S_EMIT;
        end

        default: st_q <= S_WAIT;
      endcase
    end
  end

endmodule
